FILE: hw/rtl/sste_pkg.sv
package sste_pkg;

  localparam int WORD_W = 32;
  localparam int VAL_W = 64;
  localparam int SLOT_W = 6;
  localparam int KIND_W = 3;

  localparam int INDEX_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [SLOT_W-1:0] TILE_LEN_RST = 6'd32;

  localparam logic [KIND_W-1:0] KIND_ENTRY = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HEADER = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TERM = 3'd4;

  localparam int NUM_BEATS = 6;
  localparam int BEAT_DIR = 0;
  localparam int BEAT_ENTRY = 1;
  localparam int BEAT_HDR = 2;
  localparam int BEAT_END = 3;
  localparam int BEAT_LAST_HDR = 4;
  localparam int BEAT_TERM = 5;

  typedef struct packed {
    logic              has_dir;
    logic [WORD_W-1:0] row;
    logic [WORD_W-1:0] dir_start;
    logic [WORD_W-1:0] dir_pos;
    logic [WORD_W-1:0] tile;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] col;
    logic [WORD_W-1:0] dep;
    logic [VAL_W-1:0]  val;
    logic              full;
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] hdr_last;
    logic [VAL_W-1:0]  bitmap;
    logic              last;
    logic [WORD_W-1:0] tile_end;
    logic [SLOT_W-1:0] slot_end;
    logic [WORD_W-1:0] first_end;
    logic [VAL_W-1:0]  bitmap_end;
    logic [WORD_W-1:0] total_nz;
    logic [WORD_W-1:0] total_dir;
  } job_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] tile;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [VAL_W-1:0]  word_c;
    logic              final_result;
  } res_t;

endpackage

FILE: hw/rtl/sste_front.sv
module sste_front #(
  parameter int INDEX_BITS = sste_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sste_pkg::SLOT_W-1:0]      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sste_pkg::WORD_W-1:0]      in_row_index,
  input  logic [sste_pkg::WORD_W-1:0]      in_col_index,
  input  logic [sste_pkg::WORD_W-1:0]      in_depth_index,
  input  logic [sste_pkg::VAL_W-1:0]       in_value_bits,
  input  logic                             in_last_item,
  input  logic                             push_ready,
  output logic                             push,
  output sste_pkg::job_t                   push_job
);

  logic [sste_pkg::SLOT_W-1:0] tile_len_r;
  logic [INDEX_BITS-1:0]       cur_row_r;
  logic                        started_r;
  logic [sste_pkg::WORD_W-1:0] dir_cnt_r;
  logic [sste_pkg::WORD_W-1:0] nz_cnt_r;
  logic [sste_pkg::WORD_W-1:0] tile_cnt_r;
  logic [sste_pkg::SLOT_W-1:0] slot_r;
  logic [sste_pkg::VAL_W-1:0]  bitmap_r;
  logic [sste_pkg::WORD_W-1:0] first_r;

  logic [INDEX_BITS-1:0]       row_m;
  logic [sste_pkg::SLOT_W-1:0] len;
  logic                        same_row;
  logic                        new_row;
  logic [sste_pkg::WORD_W-1:0] dir_cnt_nxt;
  logic [sste_pkg::WORD_W-1:0] hdr_last;
  logic [sste_pkg::VAL_W-1:0]  bitmap_shift;
  logic                        full;
  logic [sste_pkg::WORD_W-1:0] tile_cnt_nxt;
  logic [sste_pkg::SLOT_W-1:0] slot_nxt;
  logic [sste_pkg::VAL_W-1:0]  bitmap_nxt;
  logic [sste_pkg::WORD_W-1:0] first_nxt;
  logic [sste_pkg::WORD_W-1:0] nz_cnt_nxt;

  assign in_ready = push_ready;
  assign push = in_valid && push_ready;

  assign row_m = in_row_index[INDEX_BITS-1:0];
  assign len = (tile_len_r == '0) ? sste_pkg::SLOT_W'(1) : tile_len_r;
  assign same_row = started_r && (row_m == cur_row_r);
  assign new_row = !same_row;
  assign dir_cnt_nxt = dir_cnt_r + sste_pkg::WORD_W'(new_row);
  assign hdr_last = dir_cnt_nxt - sste_pkg::WORD_W'(1);
  assign bitmap_shift = {bitmap_r[sste_pkg::VAL_W-2:0], (!started_r || same_row)};
  assign full = (slot_r >= len);
  assign tile_cnt_nxt = tile_cnt_r + sste_pkg::WORD_W'(full);
  assign slot_nxt = full ? sste_pkg::SLOT_W'(1) : (slot_r + sste_pkg::SLOT_W'(1));
  assign bitmap_nxt = full ? sste_pkg::VAL_W'(1) : bitmap_shift;
  assign first_nxt = full ? hdr_last : first_r;
  assign nz_cnt_nxt = nz_cnt_r + sste_pkg::WORD_W'(1);

  always_comb begin
    push_job.has_dir = new_row;
    push_job.row = sste_pkg::WORD_W'(row_m);
    push_job.dir_start = nz_cnt_r;
    push_job.dir_pos = dir_cnt_r;
    push_job.tile = tile_cnt_r;
    push_job.slot = slot_r;
    push_job.col = sste_pkg::WORD_W'(in_col_index[INDEX_BITS-1:0]);
    push_job.dep = sste_pkg::WORD_W'(in_depth_index[INDEX_BITS-1:0]);
    push_job.val = in_value_bits;
    push_job.full = full;
    push_job.first = first_r;
    push_job.hdr_last = hdr_last;
    push_job.bitmap = bitmap_shift;
    push_job.last = in_last_item;
    push_job.tile_end = tile_cnt_nxt;
    push_job.slot_end = slot_nxt;
    push_job.first_end = first_nxt;
    push_job.bitmap_end = bitmap_nxt;
    push_job.total_nz = nz_cnt_nxt;
    push_job.total_dir = dir_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_len_r <= sste_pkg::TILE_LEN_RST;
    end else if (cfg_we) begin
      tile_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      started_r <= 1'b0;
      dir_cnt_r <= '0;
      nz_cnt_r <= '0;
      tile_cnt_r <= '0;
      slot_r <= sste_pkg::SLOT_W'(1);
      bitmap_r <= sste_pkg::VAL_W'(1);
      first_r <= '0;
    end else if (push) begin
      if (in_last_item) begin
        cur_row_r <= '0;
        started_r <= 1'b0;
        dir_cnt_r <= '0;
        nz_cnt_r <= '0;
        tile_cnt_r <= '0;
        slot_r <= sste_pkg::SLOT_W'(1);
        bitmap_r <= sste_pkg::VAL_W'(1);
        first_r <= '0;
      end else begin
        cur_row_r <= row_m;
        started_r <= 1'b1;
        dir_cnt_r <= dir_cnt_nxt;
        nz_cnt_r <= nz_cnt_nxt;
        tile_cnt_r <= tile_cnt_nxt;
        slot_r <= slot_nxt;
        bitmap_r <= bitmap_nxt;
        first_r <= first_nxt;
      end
    end
  end

endmodule

FILE: hw/rtl/sste_queue.sv
module sste_queue #(
  parameter int DEPTH = sste_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sste_pkg::job_t push_job,
  output logic           push_ready,
  input  logic           pop,
  output logic           head_valid,
  output sste_pkg::job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sste_pkg::job_t    slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_nxt;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job = slots_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_r + PTR_W'(1));
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_r + PTR_W'(1));

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/sste_back.sv
module sste_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  sste_pkg::job_t                head_job,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sste_pkg::KIND_W-1:0]   out_kind,
  output logic [sste_pkg::WORD_W-1:0]   out_tile_number,
  output logic [sste_pkg::SLOT_W-1:0]   out_slot,
  output logic [sste_pkg::WORD_W-1:0]   out_word_a,
  output logic [sste_pkg::WORD_W-1:0]   out_word_b,
  output logic [sste_pkg::VAL_W-1:0]    out_word_c,
  output logic                          out_final_result
);

  logic [sste_pkg::NUM_BEATS-1:0] done_r;
  logic                           out_valid_r;
  sste_pkg::res_t                 out_r;

  logic [sste_pkg::NUM_BEATS-1:0] need;
  logic [sste_pkg::NUM_BEATS-1:0] pend;
  logic [sste_pkg::NUM_BEATS-1:0] sel;
  logic                           is_final;
  logic                           load;
  sste_pkg::res_t                 res;

  always_comb begin
    need = '0;
    need[sste_pkg::BEAT_DIR] = head_job.has_dir;
    need[sste_pkg::BEAT_ENTRY] = 1'b1;
    need[sste_pkg::BEAT_HDR] = head_job.full;
    need[sste_pkg::BEAT_END] = head_job.last;
    need[sste_pkg::BEAT_LAST_HDR] = head_job.last;
    need[sste_pkg::BEAT_TERM] = head_job.last;
  end

  assign pend = need & ~done_r;
  assign sel = pend & (~pend + sste_pkg::NUM_BEATS'(1));
  assign is_final = ((pend & ~sel) == '0);
  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop = load && is_final;

  // one result word per beat, in stream order
  always_comb begin
    res.kind = sste_pkg::KIND_ENTRY;
    res.tile = head_job.tile;
    res.slot = head_job.slot;
    res.word_a = head_job.col;
    res.word_b = head_job.dep;
    res.word_c = head_job.val;
    res.final_result = is_final;
    if (sel[sste_pkg::BEAT_DIR]) begin
      res.kind = sste_pkg::KIND_DIR;
      res.tile = '0;
      res.slot = '0;
      res.word_a = head_job.row;
      res.word_b = head_job.dir_start;
      res.word_c = sste_pkg::VAL_W'(head_job.dir_pos);
    end else if (sel[sste_pkg::BEAT_HDR]) begin
      res.kind = sste_pkg::KIND_HEADER;
      res.slot = '0;
      res.word_a = head_job.first;
      res.word_b = head_job.hdr_last;
      res.word_c = head_job.bitmap;
    end else if (sel[sste_pkg::BEAT_END]) begin
      res.kind = sste_pkg::KIND_END;
      res.tile = head_job.tile_end;
      res.slot = head_job.slot_end;
      res.word_a = '1;
      res.word_b = '1;
      res.word_c = '1;
    end else if (sel[sste_pkg::BEAT_LAST_HDR]) begin
      res.kind = sste_pkg::KIND_HEADER;
      res.tile = head_job.tile_end;
      res.slot = '0;
      res.word_a = head_job.first_end;
      res.word_b = head_job.hdr_last;
      res.word_c = head_job.bitmap_end;
    end else if (sel[sste_pkg::BEAT_TERM]) begin
      res.kind = sste_pkg::KIND_TERM;
      res.tile = '0;
      res.slot = '0;
      res.word_a = '0;
      res.word_b = head_job.total_nz;
      res.word_c = sste_pkg::VAL_W'(head_job.total_dir);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        done_r <= is_final ? '0 : (done_r | sel);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_r.kind;
  assign out_tile_number = out_r.tile;
  assign out_slot = out_r.slot;
  assign out_word_a = out_r.word_a;
  assign out_word_b = out_r.word_b;
  assign out_word_c = out_r.word_c;
  assign out_final_result = out_r.final_result;

endmodule

FILE: hw/rtl/sparse_tensor_tile_encoder.sv
// channel   direction  handshake            payload
// in_       input      in_valid/in_ready    row, col, depth index, value bits, last
// out_      output     out_valid/out_ready  kind, tile, slot, words a/b/c, final
// cfg_      input      cfg_we               tile length, 6 bits
//
// front takes one word per cycle while the job queue has room
// back emits one result word per cycle unless out_ready stalls it: one to six per item
// sustained rate set by the back sequencer, which pops an item with its final word
// rst_n synchronous, active low; tile length returns to 32
// out_ register parts the sides; a stalled output fills the queue, then in_ready drops
module sparse_tensor_tile_encoder #(
  parameter int INDEX_BITS = sste_pkg::INDEX_BITS_DEF,
  parameter int QUEUE_DEPTH = sste_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sste_pkg::SLOT_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sste_pkg::WORD_W-1:0]   in_row_index,
  input  logic [sste_pkg::WORD_W-1:0]   in_col_index,
  input  logic [sste_pkg::WORD_W-1:0]   in_depth_index,
  input  logic [sste_pkg::VAL_W-1:0]    in_value_bits,
  input  logic                          in_last_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sste_pkg::KIND_W-1:0]   out_kind,
  output logic [sste_pkg::WORD_W-1:0]   out_tile_number,
  output logic [sste_pkg::SLOT_W-1:0]   out_slot,
  output logic [sste_pkg::WORD_W-1:0]   out_word_a,
  output logic [sste_pkg::WORD_W-1:0]   out_word_b,
  output logic [sste_pkg::VAL_W-1:0]    out_word_c,
  output logic                          out_final_result
);

  logic           push;
  logic           push_ready;
  sste_pkg::job_t push_job;
  logic           pop;
  logic           head_valid;
  sste_pkg::job_t head_job;

  sste_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_row_index(in_row_index),
    .in_col_index(in_col_index),
    .in_depth_index(in_depth_index),
    .in_value_bits(in_value_bits),
    .in_last_item(in_last_item),
    .push_ready(push_ready),
    .push(push),
    .push_job(push_job)
  );

  sste_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_job(push_job),
    .push_ready(push_ready),
    .pop(pop),
    .head_valid(head_valid),
    .head_job(head_job)
  );

  sste_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .head_valid(head_valid),
    .head_job(head_job),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_tile_number(out_tile_number),
    .out_slot(out_slot),
    .out_word_a(out_word_a),
    .out_word_b(out_word_b),
    .out_word_c(out_word_c),
    .out_final_result(out_final_result)
  );

endmodule
